@@ rtl/wjos_pkg.sv @@
// wjos_pkg: shared types and constants for the weighted job order scheduler
// no dependencies
`timescale 1ns / 1ps
package wjos_pkg;

  localparam int MaxJobs   = 64;
  localparam int IdxW      = $clog2(MaxJobs);
  localparam int CntW      = IdxW + 1;
  localparam int DurW      = 16;
  localparam int WgtW      = 16;
  localparam int EntryW    = DurW + WgtW + IdxW;
  localparam int PrefixW   = 22;
  localparam int ProdW     = WgtW + PrefixW;
  localparam int DelayW    = 43;
  localparam int SumW      = 44;
  localparam int JobNumW   = 7;

  typedef struct packed {
    logic [DurW-1:0] duration;
    logic [WgtW-1:0] weight;
    logic            last_job;
  } job_in_t;

  typedef struct packed {
    logic [JobNumW-1:0] job_number;
    logic [DelayW-1:0]  total_delay;
    logic               dropped;
    logic               last_result;
  } job_out_t;

  typedef struct packed {
    logic [IdxW-1:0] index;
    logic [WgtW-1:0] weight;
    logic [DurW-1:0] duration;
  } entry_t;

  // true when a must be placed strictly before b
  function automatic logic goes_before(entry_t a, entry_t b);
    logic [31:0] lhs;
    logic [31:0] rhs;
    lhs = 32'(a.weight) * 32'(b.duration);
    rhs = 32'(b.weight) * 32'(a.duration);
    return lhs > rhs;
  endfunction

endpackage

@@ rtl/wjos_ram.sv @@
// wjos_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
`timescale 1ns / 1ps
module wjos_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ rtl/weighted_job_order_scheduler.sv @@
// weighted_job_order_scheduler: top level, sequencer around the job ram
// depends on wjos_pkg and wjos_ram
//
// Usage: a job beat is taken at a clock edge where start is high and busy
// is low. While idle, jobs are written to the job ram one per cycle and may
// arrive back to back. A job with last_job set closes the set and raises
// busy from the next cycle. A set of two or more jobs is then sorted in the
// ram by insertion: each pass reads a candidate, captures it while reading
// its left neighbor and compares, shifting each neighbor that it goes before
// one place right and then placing the candidate in the hole. A second pass
// forms the weighted delay, and a last pass emits one result per job. Each
// result is held for one cycle with valid_o high; the receiver cannot
// stall, so there is no backpressure. busy drops the cycle after the final
// result. Reset returns control to idle and empties the set; ram contents
// are not cleared. Jobs beyond 64 in a set are dropped and flag dropped on
// every result of that set.
`timescale 1ns / 1ps
module weighted_job_order_scheduler
  import wjos_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  job_in_t  job_i,
  output logic     busy,
  output logic     valid_o,
  output job_out_t result_o
);
  typedef enum logic [9:0] {
    StIdle   = 10'b00_0000_0001,
    StSRd    = 10'b00_0000_0010,  // read candidate
    StSLoad  = 10'b00_0000_0100,  // capture candidate, read left neighbor
    StSCmp   = 10'b00_0000_1000,  // compare, shift or place
    StSPlace = 10'b00_0001_0000,  // place candidate at position 0
    StSumRd  = 10'b00_0010_0000,
    StSumAc  = 10'b00_0100_0000,
    StMulAc  = 10'b00_1000_0000,
    StOutRd  = 10'b01_0000_0000,
    StOutWr  = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;
  logic [CntW-1:0] i_q, i_d;      // insertion pass / scan position
  logic [IdxW-1:0] j_q, j_d;      // current hole
  entry_t          cur_q, cur_d;
  logic [PrefixW-1:0] prefix_q, prefix_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [ProdW-1:0]   prod_q, prod_d;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t          wdata, rdata;
  logic            accept;
  logic            ahead;
  logic [DurW-1:0] dur_in;

  wjos_ram #(.Width(EntryW), .Depth(MaxJobs)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy   = (state_q != StIdle);
  assign accept = start && !busy;
  assign dur_in = (job_i.duration == '0) ? DurW'(1) : job_i.duration;
  assign ahead  = goes_before(cur_q, rdata);

  // sequencer
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    i_d      = i_q;
    j_d      = j_q;
    cur_d    = cur_q;
    prefix_d = prefix_q;
    sum_d    = sum_q;
    prod_d   = prod_q;
    we       = 1'b0;
    waddr    = j_q;
    wdata    = cur_q;
    raddr    = '0;
    valid_o  = 1'b0;
    result_o = '0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (count_q < CntW'(MaxJobs)) begin
            we      = 1'b1;
            waddr   = count_q[IdxW-1:0];
            wdata   = '{index: count_q[IdxW-1:0], weight: job_i.weight,
                        duration: dur_in};
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (job_i.last_job) begin
            prefix_d = '0;
            sum_d    = '0;
            i_d      = '0;
            state_d  = StSumRd;  // a single job needs no sort
            if (count_d > CntW'(1)) begin
              i_d     = CntW'(1);
              state_d = StSRd;
            end
          end
        end
      end
      StSRd: begin
        raddr   = i_q[IdxW-1:0];
        state_d = StSLoad;
      end
      StSLoad: begin
        cur_d   = rdata;
        j_d     = i_q[IdxW-1:0];
        raddr   = i_q[IdxW-1:0] - 1'b1;
        state_d = StSCmp;
      end
      StSCmp: begin
        we = 1'b1;
        if (ahead) begin
          // shift the neighbor right and move the hole left
          waddr = j_q;
          wdata = rdata;
          j_d   = j_q - 1'b1;
          if (j_q == IdxW'(1)) begin
            state_d = StSPlace;
          end else begin
            raddr = j_q - IdxW'(2);
          end
        end else begin
          waddr = j_q;
          wdata = cur_q;
          if (i_q + 1'b1 >= count_q) begin
            i_d = '0; state_d = StSumRd;
          end else begin
            i_d = i_q + 1'b1; state_d = StSRd;
          end
        end
      end
      StSPlace: begin
        we    = 1'b1;
        waddr = '0;
        wdata = cur_q;
        if (i_q + 1'b1 >= count_q) begin
          i_d = '0; state_d = StSumRd;
        end else begin
          i_d = i_q + 1'b1; state_d = StSRd;
        end
      end
      StSumRd: begin
        raddr   = i_q[IdxW-1:0];
        state_d = StSumAc;
      end
      StSumAc: begin
        prod_d   = ProdW'(rdata.weight) * ProdW'(prefix_q);
        prefix_d = prefix_q + PrefixW'(rdata.duration);
        state_d  = StMulAc;
      end
      StMulAc: begin
        sum_d = sum_q + SumW'(prod_q);
        if (i_q + 1'b1 >= count_q) begin
          i_d = '0; state_d = StOutRd;
        end else begin
          i_d = i_q + 1'b1; state_d = StSumRd;
        end
      end
      StOutRd: begin
        raddr   = i_q[IdxW-1:0];
        state_d = StOutWr;
      end
      StOutWr: begin
        valid_o = 1'b1;
        result_o.job_number  = JobNumW'(rdata.index) + 1'b1;
        result_o.total_delay = sum_q[DelayW-1:0];
        result_o.dropped     = ovf_q;
        result_o.last_result = (i_q + 1'b1 == count_q);
        if (i_q + 1'b1 == count_q) begin
          state_d  = StIdle;
          count_d  = '0;
          ovf_d    = 1'b0;
          i_d      = '0;
          prefix_d = '0;
          sum_d    = '0;
        end else begin
          i_d = i_q + 1'b1; state_d = StOutRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      prefix_q <= '0;
      sum_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      prefix_q <= prefix_d;
      sum_q    <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prod_q <= prod_d;
  end

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy) else $error("result while idle");
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxJobs)) else $error("count overflow");
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CntW'(MaxJobs))) else $error("drop while not full");
endmodule
